// ===== src/lsec_pkg.sv =====
// lsec_pkg: shared types, register indexes and constants for the lattice site energy core
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps
`default_nettype none
package lsec_pkg;

	localparam int SITES_DEF      = 4096;
	localparam int VALUE_BITS_DEF = 16;

	localparam int IDX_W   = 12;
	localparam int VAL_W   = 16;
	localparam int RES_W   = 52;
	localparam int SIZE_W  = 7;
	localparam int COORD_W = 6;
	localparam int GEO_W   = 25;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_EVAL  = 1'b1;

	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_X   = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Y   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_Z   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SIZE_T   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_COUPLING = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_FIELD    = 3'd5;

	localparam logic [SIZE_W-1:0] SIZE_MIN = 7'd1;
	localparam logic [SIZE_W-1:0] SIZE_MAX = 7'd64;

	typedef struct packed {
		logic                    opcode;
		logic [IDX_W-1:0]        site_index;
		logic signed [VAL_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic signed [RES_W-1:0] delta_new;
		logic signed [RES_W-1:0] delta_old;
		logic                    status;
	} res_t;

	typedef struct packed {
		logic [SIZE_W-1:0]       sx;
		logic [SIZE_W-1:0]       sy;
		logic [SIZE_W-1:0]       sz;
		logic [SIZE_W-1:0]       st;
		logic [GEO_W-1:0]        sxy;
		logic [GEO_W-1:0]        sxyz;
		logic [GEO_W-1:0]        vol;
		logic signed [VAL_W-1:0] coupling;
		logic signed [VAL_W-1:0] field;
	} geom_t;

	typedef struct packed {
		logic                    opcode;
		logic                    bad;
		logic [IDX_W-1:0]        idx;
		logic signed [VAL_W-1:0] value;
		logic [COORD_W-1:0]      x;
		logic [COORD_W-1:0]      y;
		logic [COORD_W-1:0]      z;
		logic [COORD_W-1:0]      t;
	} entry_t;

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) r = SIZE_MIN;
		else if (v > SIZE_MAX) r = SIZE_MAX;
		else r = v;
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== src/lsec_front.sv =====
// lsec_front: accepts commands and splits the site index into x, y, z, t
// by a shared bit-serial divider; uses lsec_pkg
`timescale 1ns / 1ps
`default_nettype none
module lsec_front #(
	parameter int SITES = lsec_pkg::SITES_DEF
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            start,
	output logic                 busy,
	input  wire lsec_pkg::cmd_t  cmd,
	input  wire lsec_pkg::geom_t geom,
	output logic                 push,
	output lsec_pkg::entry_t     push_data,
	input  wire logic            full
);
	import lsec_pkg::*;

	typedef enum logic [2:0] {
		F_IDLE = 3'b001,
		F_DIV  = 3'b010,
		F_PUSH = 3'b100
	} fstate_t;

	localparam logic [1:0] PH_X = 2'd0;
	localparam logic [1:0] PH_Y = 2'd1;
	localparam logic [1:0] PH_Z = 2'd2;
	localparam logic [3:0] LAST_BIT = 4'(IDX_W - 1);

	fstate_t state_q;
	logic [1:0] ph_q;
	logic [3:0] bit_q;
	logic [IDX_W-1:0] num_q;
	logic [SIZE_W-1:0] rem_q;
	logic op_q;
	logic [IDX_W-1:0] idx_q;
	logic signed [VAL_W-1:0] val_q;
	logic [COORD_W-1:0] x_q, y_q, z_q, t_q;

	logic [SIZE_W-1:0] dsel;
	logic [SIZE_W:0] trial;
	logic ge;
	logic [SIZE_W-1:0] rem_nx;
	logic [IDX_W-1:0] num_nx;
	logic bad;

	always_comb begin
		case (ph_q)
			PH_X: dsel = geom.sx;
			PH_Y: dsel = geom.sy;
			default: dsel = geom.sz;
		endcase
		trial  = {rem_q, num_q[IDX_W-1]};
		ge     = trial >= {1'b0, dsel};
		rem_nx = ge ? SIZE_W'(trial - {1'b0, dsel}) : trial[SIZE_W-1:0];
		num_nx = {num_q[IDX_W-2:0], ge};
		bad    = (GEO_W'(idx_q) >= geom.vol) || (GEO_W'(idx_q) >= GEO_W'(SITES));
	end

	assign busy = (state_q != F_IDLE);
	assign push = (state_q == F_PUSH) && !full;
	assign push_data = '{opcode: op_q, bad: bad, idx: idx_q, value: val_q,
		x: x_q, y: y_q, z: z_q, t: t_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ph_q <= PH_X;
			bit_q <= '0;
		end else begin
			case (state_q)
				F_IDLE: begin
					if (start) begin
						state_q <= F_DIV;
						ph_q <= PH_X;
						bit_q <= '0;
					end
				end
				F_DIV: begin
					bit_q <= bit_q + 4'd1;
					if (bit_q == LAST_BIT) begin
						bit_q <= '0;
						case (ph_q)
							PH_X: ph_q <= PH_Y;
							PH_Y: ph_q <= PH_Z;
							default: state_q <= F_PUSH;
						endcase
					end
				end
				F_PUSH: begin
					if (!full) state_q <= F_IDLE;
				end
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// divider datapath: quotient shifts into num_q, next phase divides it again
	always_ff @(posedge clk) begin
		if (state_q == F_IDLE && start) begin
			op_q <= cmd.opcode;
			idx_q <= cmd.site_index;
			val_q <= cmd.value;
			num_q <= cmd.site_index;
			rem_q <= '0;
		end else if (state_q == F_DIV) begin
			num_q <= num_nx;
			rem_q <= rem_nx;
			if (bit_q == LAST_BIT) begin
				rem_q <= '0;
				case (ph_q)
					PH_X: x_q <= rem_nx[COORD_W-1:0];
					PH_Y: y_q <= rem_nx[COORD_W-1:0];
					default: begin
						z_q <= rem_nx[COORD_W-1:0];
						t_q <= num_nx[COORD_W-1:0];
					end
				endcase
			end
		end
	end

endmodule
`default_nettype wire

// ===== src/lsec_fifo.sv =====
// lsec_fifo: two-entry queue of classified commands between front and back
// uses lsec_pkg for the entry type
`timescale 1ns / 1ps
`default_nettype none
module lsec_fifo (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire lsec_pkg::entry_t push_data,
	output logic                  full,
	input  wire logic             pop,
	output lsec_pkg::entry_t      head,
	output logic                  empty
);
	import lsec_pkg::*;

	entry_t slot_q [2];
	logic wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = slot_q[rp_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= 1'b0;
			rp_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop) rp_q <= ~rp_q;
			case ({push, pop})
				2'b10: cnt_q <= cnt_q + 2'd1;
				2'b01: cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push) slot_q[wp_q] <= push_data;
	end

endmodule
`default_nettype wire

// ===== src/lsec_back.sv =====
// lsec_back: holds the lattice store, walks the neighbour reads and forms both deltas
// uses lsec_pkg; fed from lsec_fifo
`timescale 1ns / 1ps
`default_nettype none
module lsec_back #(
	parameter int SITES      = lsec_pkg::SITES_DEF,
	parameter int VALUE_BITS = lsec_pkg::VALUE_BITS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire lsec_pkg::geom_t  geom,
	input  wire logic             empty,
	input  wire lsec_pkg::entry_t head,
	output logic                  pop,
	output logic                  done,
	output lsec_pkg::res_t        result
);
	import lsec_pkg::*;

	localparam int ADDR_W = $clog2(SITES);
	localparam int NEI_W  = VALUE_BITS + 4;
	localparam int S_W    = NEI_W + VAL_W + 1;
	localparam int DN_W   = S_W + VAL_W;
	localparam int DO_W   = S_W + VALUE_BITS;

	localparam logic [3:0] NB_SELF  = 4'd0;
	localparam logic [3:0] NB_XP    = 4'd1;
	localparam logic [3:0] NB_XM    = 4'd2;
	localparam logic [3:0] NB_TP    = 4'd3;
	localparam logic [3:0] NB_TM    = 4'd4;
	localparam logic [3:0] NB_YP    = 4'd5;
	localparam logic [3:0] NB_YM    = 4'd6;
	localparam logic [3:0] NB_ZP    = 4'd7;
	localparam logic [3:0] NB_ZM    = 4'd8;

	typedef enum logic [5:0] {
		B_IDLE  = 6'b000001,
		B_READ  = 6'b000010,
		B_DRAIN = 6'b000100,
		B_MS    = 6'b001000,
		B_MUL   = 6'b010000,
		B_OUT   = 6'b100000
	} bstate_t;

	bstate_t state_q;
	logic [3:0] nb_q;
	entry_t e_q;
	logic rd_v_q, rd_self_q, rd_use_q;
	logic signed [VALUE_BITS-1:0] rdata_q;
	logic signed [NEI_W-1:0] nei_q;
	logic signed [VALUE_BITS-1:0] stored_q;
	logic signed [S_W-1:0] s_q;
	logic signed [DN_W-1:0] dn_q;
	logic signed [DO_W-1:0] do_q;

	logic signed [VALUE_BITS-1:0] mem [SITES];

	logic [GEO_W-1:0] idx25, sx25, addr;
	logic nb_en, mem_we, mem_re;

	always_comb begin
		idx25 = GEO_W'(e_q.idx);
		sx25  = GEO_W'(geom.sx);
		nb_en = 1'b1;
		case (nb_q)
			NB_SELF: addr = idx25;
			NB_XP: addr = ({1'b0, e_q.x} == geom.sx - 7'd1) ? idx25 - (sx25 - 25'd1)
				: idx25 + 25'd1;
			NB_XM: addr = (e_q.x == '0) ? idx25 + (sx25 - 25'd1) : idx25 - 25'd1;
			NB_TP: addr = ({1'b0, e_q.t} == geom.st - 7'd1)
				? idx25 - (geom.vol - geom.sxyz) : idx25 + geom.sxyz;
			NB_TM: addr = (e_q.t == '0) ? idx25 + (geom.vol - geom.sxyz)
				: idx25 - geom.sxyz;
			NB_YP: begin
				nb_en = (geom.sy != 7'd1);
				addr = ({1'b0, e_q.y} == geom.sy - 7'd1) ? idx25 - (geom.sxy - sx25)
					: idx25 + sx25;
			end
			NB_YM: begin
				nb_en = (geom.sy != 7'd1);
				addr = (e_q.y == '0) ? idx25 + (geom.sxy - sx25) : idx25 - sx25;
			end
			NB_ZP: begin
				nb_en = (geom.sz != 7'd1);
				addr = ({1'b0, e_q.z} == geom.sz - 7'd1)
					? idx25 - (geom.sxyz - geom.sxy) : idx25 + geom.sxy;
			end
			default: begin
				nb_en = (geom.sz != 7'd1);
				addr = (e_q.z == '0) ? idx25 + (geom.sxyz - geom.sxy)
					: idx25 - geom.sxy;
			end
		endcase
		pop    = (state_q == B_IDLE) && !empty;
		mem_we = pop && (head.opcode == OP_WRITE) && !head.bad;
		mem_re = (state_q == B_READ);
	end

	always_ff @(posedge clk) begin
		if (mem_we) mem[head.idx[ADDR_W-1:0]] <= VALUE_BITS'(head.value);
		if (mem_re) rdata_q <= mem[addr[ADDR_W-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
			nb_q <= '0;
			rd_v_q <= 1'b0;
		end else begin
			rd_v_q <= (state_q == B_READ);
			case (state_q)
				B_IDLE: begin
					if (!empty) begin
						nb_q <= NB_SELF;
						if (head.opcode == OP_EVAL && !head.bad) state_q <= B_READ;
						else state_q <= B_OUT;
					end
				end
				B_READ: begin
					nb_q <= nb_q + 4'd1;
					if (nb_q == NB_ZM) state_q <= B_DRAIN;
				end
				B_DRAIN: state_q <= B_MS;
				B_MS:    state_q <= B_MUL;
				B_MUL:   state_q <= B_OUT;
				B_OUT:   state_q <= B_IDLE;
				default: state_q <= B_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		rd_self_q <= (nb_q == NB_SELF);
		rd_use_q <= nb_en && (addr < GEO_W'(SITES));
		case (state_q)
			B_IDLE: begin
				e_q <= head;
				nei_q <= '0;
				stored_q <= '0;
				dn_q <= '0;
				do_q <= '0;
			end
			B_MS: s_q <= S_W'(geom.coupling) * S_W'(nei_q) + (S_W'(geom.field) <<< 8);
			B_MUL: begin
				dn_q <= DN_W'(s_q) * DN_W'(e_q.value);
				do_q <= DO_W'(s_q) * DO_W'(stored_q);
			end
			default: ;
		endcase
		// read data lands in the cycle after its address
		if (rd_v_q && rd_use_q) begin
			if (rd_self_q) stored_q <= rdata_q;
			else nei_q <= nei_q + NEI_W'(rdata_q);
		end
	end

	assign done = (state_q == B_OUT);
	assign result = '{delta_new: RES_W'(dn_q), delta_old: RES_W'(do_q), status: e_q.bad};

endmodule
`default_nettype wire

// ===== src/lattice_site_energy_change_core.sv =====
// lattice site energy change core: 4D periodic lattice store with local energy evaluation
// a command is taken while busy is low; busy then stays high while the bit-serial index divider
// runs (three 12-step divides) and until the entry is pushed into the queue, which waits while
// the queue is full, so no new command is taken before the last one is queued; neighbour reads
// share one memory port, nine reads per evaluate
// asynchronous active-low reset restores the register defaults; the store is not cleared
// results appear for one cycle on done; the receiver cannot stall
`timescale 1ns / 1ps
`default_nettype none
module lattice_site_energy_change_core #(
	parameter int SITES      = lsec_pkg::SITES_DEF,
	parameter int VALUE_BITS = lsec_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire lsec_pkg::cmd_t                      cmd,
	output logic                                     done,
	output lsec_pkg::res_t                           result,
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [lsec_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [lsec_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import lsec_pkg::*;

	logic [SIZE_W-1:0] sx_q, sy_q, sz_q, st_q;
	logic signed [VAL_W-1:0] coupling_q, field_q;
	logic [GEO_W-1:0] sxy_q, sxyz_q, vol_q;
	geom_t geom;

	logic push, full, pop, empty;
	entry_t push_data, head;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sx_q <= 7'd16;
			sy_q <= 7'd16;
			sz_q <= 7'd1;
			st_q <= 7'd16;
			coupling_q <= 16'sd256;
			field_q <= '0;
			sxy_q <= 25'd256;
			sxyz_q <= 25'd256;
			vol_q <= 25'd4096;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					CFG_SIZE_X:   sx_q <= clamp_size(cfg_data[SIZE_W-1:0]);
					CFG_SIZE_Y:   sy_q <= clamp_size(cfg_data[SIZE_W-1:0]);
					CFG_SIZE_Z:   sz_q <= clamp_size(cfg_data[SIZE_W-1:0]);
					CFG_SIZE_T:   st_q <= clamp_size(cfg_data[SIZE_W-1:0]);
					CFG_COUPLING: coupling_q <= cfg_data;
					CFG_FIELD:    field_q <= cfg_data;
					default: ;
				endcase
			end
			// volume products are registered in a chain, sxy_q then sxyz_q then vol_q, and settle after a write
			sxy_q <= GEO_W'(sx_q) * GEO_W'(sy_q);
			sxyz_q <= sxy_q * GEO_W'(sz_q);
			vol_q <= sxyz_q * GEO_W'(st_q);
		end
	end

	assign geom = '{sx: sx_q, sy: sy_q, sz: sz_q, st: st_q, sxy: sxy_q, sxyz: sxyz_q,
		vol: vol_q, coupling: coupling_q, field: field_q};

	lsec_front #(.SITES(SITES)) u_front (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd), .geom(geom),
		.push(push), .push_data(push_data), .full(full)
	);

	lsec_fifo u_fifo (
		.clk(clk), .arst_n(arst_n), .push(push), .push_data(push_data), .full(full),
		.pop(pop), .head(head), .empty(empty)
	);

	lsec_back #(.SITES(SITES), .VALUE_BITS(VALUE_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .geom(geom), .empty(empty), .head(head), .pop(pop),
		.done(done), .result(result)
	);

endmodule
`default_nettype wire

// ===== dv/lattice_site_energy_change_core_tb.sv =====
// lattice_site_energy_change_core_tb: self-checking bench for the lattice site energy core
// depends on lsec_pkg and lattice_site_energy_change_core; a shadow store predicts every result
`timescale 1ns / 1ps
`default_nettype none
module lattice_site_energy_change_core_tb;
	import lsec_pkg::*;

	localparam int STORE_DEPTH = 4096;
	localparam int FILL_DEPTH  = 256;
	localparam int STALL_LIMIT = 4000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	cmd_t cmd = '0;
	logic done;
	res_t result;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	lattice_site_energy_change_core dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .cmd(cmd),
		.done(done), .result(result), .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// shadow of the block state
	logic signed [VAL_W-1:0] site_store [STORE_DEPTH];
	int unsigned ext_x = 16, ext_y = 16, ext_z = 1, ext_t = 16;
	longint coupling_k = 256, field_h = 0;
	res_t energy_due [$];
	int fail_count = 0;
	int burst_left = 0;
	bit gaps_on = 1'b1;

	function automatic int unsigned lattice_volume();
		return ext_x * ext_y * ext_z * ext_t;
	endfunction

	function automatic longint site_at(int unsigned a);
		if (a >= STORE_DEPTH) return 0;
		return longint'(site_store[a]);
	endfunction

	function automatic int unsigned site_addr(int unsigned px, int unsigned py,
			int unsigned pz, int unsigned pt);
		return px + ext_x * (py + ext_y * (pz + ext_z * pt));
	endfunction

	function automatic res_t predict_energy(cmd_t c);
		res_t r;
		int unsigned x, y, z, t, i;
		longint nsum, s, v;
		r = '0;
		i = c.site_index;
		v = longint'(c.value);
		if (i >= lattice_volume() || i >= STORE_DEPTH) begin
			r.status = 1'b1;
			return r;
		end
		if (c.opcode == OP_WRITE) begin
			site_store[i] = c.value;
			return r;
		end
		x = i % ext_x;
		y = (i / ext_x) % ext_y;
		z = (i / (ext_x * ext_y)) % ext_z;
		t = i / (ext_x * ext_y * ext_z);
		nsum = site_at(site_addr((x + 1) % ext_x, y, z, t))
			+ site_at(site_addr((x + ext_x - 1) % ext_x, y, z, t))
			+ site_at(site_addr(x, y, z, (t + 1) % ext_t))
			+ site_at(site_addr(x, y, z, (t + ext_t - 1) % ext_t));
		if (ext_y != 1)
			nsum += site_at(site_addr(x, (y + 1) % ext_y, z, t))
				+ site_at(site_addr(x, (y + ext_y - 1) % ext_y, z, t));
		if (ext_z != 1)
			nsum += site_at(site_addr(x, y, (z + 1) % ext_z, t))
				+ site_at(site_addr(x, y, (z + ext_z - 1) % ext_z, t));
		s = coupling_k * nsum + field_h * 256;
		r.delta_new = RES_W'(s * v);
		r.delta_old = RES_W'(s * site_at(i));
		return r;
	endfunction

	// one command beat; start is left high so a following beat needs no re-raise
	task automatic send_cmd(logic op, int unsigned idx, logic [VAL_W-1:0] val);
		cmd_t c;
		c.opcode = op;
		c.site_index = IDX_W'(idx);
		c.value = val;
		if (gaps_on) begin
			if (burst_left == 0) begin
				start <= 1'b0;
				repeat ($urandom_range(1, 15)) @(posedge clk);
				burst_left = $urandom_range(1, 20);
			end
			burst_left--;
		end
		start <= 1'b1;
		cmd <= c;
		do @(posedge clk); while (busy);
		energy_due.push_back(predict_energy(c));
	endtask

	task automatic wait_drained();
		start <= 1'b0;
		while (energy_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	function automatic int unsigned clamp_ext(logic [CFG_DATA_W-1:0] d);
		int unsigned v;
		v = d[SIZE_W-1:0];
		if (v == 0) return 1;
		return (v > 64) ? 64 : v;
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] ri, logic [CFG_DATA_W-1:0] d);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_index <= ri;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (ri)
			CFG_SIZE_X: ext_x = clamp_ext(d);
			CFG_SIZE_Y: ext_y = clamp_ext(d);
			CFG_SIZE_Z: ext_z = clamp_ext(d);
			CFG_SIZE_T: ext_t = clamp_ext(d);
			CFG_COUPLING: coupling_k = longint'($signed(d));
			CFG_FIELD: field_h = longint'($signed(d));
			default: ;
		endcase
	endtask

	task automatic set_geometry(int sx, int sy, int sz, int st, int k, int h);
		write_reg(CFG_SIZE_X, CFG_DATA_W'(sx));
		write_reg(CFG_SIZE_Y, CFG_DATA_W'(sy));
		write_reg(CFG_SIZE_Z, CFG_DATA_W'(sz));
		write_reg(CFG_SIZE_T, CFG_DATA_W'(st));
		write_reg(CFG_COUPLING, CFG_DATA_W'(k));
		write_reg(CFG_FIELD, CFG_DATA_W'(h));
	endtask

	// the low sites are written once under the reset geometry; later lattices but the clamped ones stay
	// within them, and any other site a test reads is written by that test first
	task automatic test_fill_store();
		gaps_on = 1'b0;
		for (int i = 0; i < FILL_DEPTH; i++)
			send_cmd(OP_WRITE, i, VAL_W'($urandom));
		gaps_on = 1'b1;
	endtask

	task automatic test_reset_geometry();
		send_cmd(OP_WRITE, 256, 16'h7fff);
		send_cmd(OP_WRITE, 3840, 16'h8000);
		send_cmd(OP_EVAL, 0, 16'h7fff);
		send_cmd(OP_WRITE, 1, 16'h7fff);
		send_cmd(OP_WRITE, 15, 16'h7fff);
		send_cmd(OP_WRITE, 16, 16'h8000);
		send_cmd(OP_EVAL, 0, 16'h0000);
		send_cmd(OP_EVAL, 0, 16'hffff);
		// pause until the pipe is empty before the next beat
		wait_drained();
		send_cmd(OP_EVAL, 0, 16'h8000);
	endtask

	task automatic test_small_lattice();
		set_geometry(2, 1, 1, 3, -32768, 32767);
		send_cmd(OP_EVAL, 0, 16'h7fff);
		send_cmd(OP_EVAL, 5, 16'h8000);
		send_cmd(OP_WRITE, 6, 16'h1234);
		send_cmd(OP_EVAL, 6, 16'h7fff);
		send_cmd(OP_EVAL, 4095, 16'h7fff);
		set_geometry(1, 1, 1, 1, 32767, -32768);
		send_cmd(OP_EVAL, 0, 16'h7fff);
		send_cmd(OP_EVAL, 1, 16'h0001);
		send_cmd(OP_WRITE, 1, 16'h5555);
	endtask

	// size 0 acts as 1 and anything above 64 as 64; the huge volume pushes neighbours off the store
	task automatic test_clamped_sizes();
		set_geometry(0, 127, 0, 127, 256, 0);
		send_cmd(OP_WRITE, 4031, 16'h7fff);
		send_cmd(OP_WRITE, 4032, 16'h8000);
		send_cmd(OP_WRITE, 4094, 16'h7fff);
		send_cmd(OP_WRITE, 4095, 16'h8001);
		send_cmd(OP_EVAL, 0, 16'h7fff);
		send_cmd(OP_EVAL, 4095, 16'h8000);
		set_geometry(64, 64, 64, 64, 32767, 32767);
		send_cmd(OP_EVAL, 0, 16'h8000);
		send_cmd(OP_EVAL, 4095, 16'h7fff);
		send_cmd(OP_EVAL, 64, 16'h7fff);
	endtask

	task automatic test_random(int sx, int sy, int sz, int st, int k, int h, int n, bit gaps);
		int unsigned lim;
		set_geometry(sx, sy, sz, st, k, h);
		gaps_on = gaps;
		lim = lattice_volume();
		if (lim > FILL_DEPTH) lim = FILL_DEPTH;
		for (int i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0)
				send_cmd(1'($urandom_range(0, 1)), $urandom_range(0, 4095), VAL_W'($urandom));
			else
				send_cmd(($urandom_range(0, 3) == 0) ? OP_WRITE : OP_EVAL,
					$urandom_range(0, lim - 1), VAL_W'($urandom));
		end
		gaps_on = 1'b1;
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n && done) begin
			if (energy_due.size() == 0) begin
				$display("%0t unexpected result %h", $time, result);
				fail_count++;
			end else begin
				want = energy_due.pop_front();
				if (result.delta_new !== want.delta_new) begin
					$display("%0t delta_new expected %h actual %h", $time,
						want.delta_new, result.delta_new);
					fail_count++;
				end
				if (result.delta_old !== want.delta_old) begin
					$display("%0t delta_old expected %h actual %h", $time,
						want.delta_old, result.delta_old);
					fail_count++;
				end
				if (result.status !== want.status) begin
					$display("%0t status expected %b actual %b", $time,
						want.status, result.status);
					fail_count++;
				end
			end
		end
	end

	// watchdog on cycles with no beat of any kind
	int quiet_cycles = 0;
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready)) quiet_cycles <= 0;
		else quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (3) @(posedge clk);
		test_fill_store();
		test_reset_geometry();
		test_small_lattice();
		test_clamped_sizes();
		test_random(4, 4, 1, 16, 256, 0, 250, 1'b1);
		test_random(4, 4, 4, 4, -32768, 32767, 250, 1'b1);
		test_random(64, 1, 1, 4, 32767, -32768, 250, 1'b0);
		test_random(3, 5, 7, 2, $urandom_range(0, 65535), $urandom_range(0, 65535), 250, 1'b1);
		test_random(1, 8, 4, 8, 1, -1, 250, 1'b1);
		test_random(8, 2, 4, 4, $urandom_range(0, 65535), $urandom_range(0, 65535), 250, 1'b1);
		wait_drained();
		repeat (60) @(posedge clk);
		if (fail_count == 0) $display("tb: success");
		else $display("tb: failure");
		$finish;
	end
endmodule
`default_nettype wire
